/* src/read_completion_splitter_core_defines.svh */
// Assertion helpers for the splitter core.
`ifndef READ_COMPLETION_SPLITTER_CORE_DEFINES_SVH
`define READ_COMPLETION_SPLITTER_CORE_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define RCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An implication: whenever cond holds, check holds in the same cycle.
`define RCS_ASSERT_IMP(label, clk, rst_n, cond, check, msg) \
	`RCS_ASSERT(label, clk, rst_n, (cond) |-> (check), msg)

`endif

/* src/rcs_pkg.sv */
package rcs_pkg;

	localparam int unsigned ADDR_W          = 30;
	localparam int unsigned LEN_W           = 11;
	localparam int unsigned LOG2_W          = 4;
	localparam int unsigned MAX_READ_LENGTH = 1024;

	localparam logic [LOG2_W-1:0] LOG2_MIN   = 4'd5;
	localparam logic [LOG2_W-1:0] LOG2_MAX   = 4'd10;
	localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd5;

	typedef struct packed {
		logic [ADDR_W-1:0] request_address;
		logic [LEN_W-1:0]  request_length;
		logic [7:0]        request_tag;
		logic [2:0]        traffic_class;
		logic [7:0]        requester_bus;
		logic [4:0]        requester_device;
		logic [2:0]        requester_function;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] piece_address;
		logic [LEN_W-1:0]  piece_length;
		logic [LEN_W-1:0]  remaining_count;
		logic [7:0]        cpl_tag;
		logic [2:0]        cpl_traffic_class;
		logic [7:0]        cpl_bus;
		logic [4:0]        cpl_device;
		logic [2:0]        cpl_function;
		logic              last_piece;
	} cpl_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} rcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_zero;
		logic last;
		logic out_free;
	} rcs_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} rcs_state_t;

endpackage

/* src/rcs_req_if.sv */
interface rcs_req_if;
	import rcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] request_address;
	logic [LEN_W-1:0]  request_length;
	logic [7:0]        request_tag;
	logic [2:0]        traffic_class;
	logic [7:0]        requester_bus;
	logic [4:0]        requester_device;
	logic [2:0]        requester_function;

	modport source (
		output valid, request_address, request_length, request_tag, traffic_class,
		       requester_bus, requester_device, requester_function,
		input  ready
	);
	modport sink (
		input  valid, request_address, request_length, request_tag, traffic_class,
		       requester_bus, requester_device, requester_function,
		output ready
	);
endinterface

/* src/rcs_cpl_if.sv */
interface rcs_cpl_if;
	import rcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] piece_address;
	logic [LEN_W-1:0]  piece_length;
	logic [LEN_W-1:0]  remaining_count;
	logic [7:0]        cpl_tag;
	logic [2:0]        cpl_traffic_class;
	logic [7:0]        cpl_bus;
	logic [4:0]        cpl_device;
	logic [2:0]        cpl_function;
	logic              last_piece;

	modport source (
		output valid, piece_address, piece_length, remaining_count, cpl_tag,
		       cpl_traffic_class, cpl_bus, cpl_device, cpl_function, last_piece,
		input  ready
	);
	modport sink (
		input  valid, piece_address, piece_length, remaining_count, cpl_tag,
		       cpl_traffic_class, cpl_bus, cpl_device, cpl_function, last_piece,
		output ready
	);
endinterface

/* src/read_completion_splitter_core.sv */
// Channel  | Direction | Carries
// req      | in        | one memory read request header
// cpl      | out       | one completion header per piece of the request
// cfg      | in        | write of the read completion boundary (log2, doublewords)
//
// A request is accepted only while the splitter is idle. It then emits one completion
// header per cycle while the completion side is not stalled, and takes no new request
// until the last piece of the current one has been generated.
// A stalled completion holds in the output register and freezes the piece generator.
// Reset clears the controller, the output valid flag and sets the boundary to 32.
`include "read_completion_splitter_core_defines.svh"

module read_completion_splitter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rcs_pkg::LOG2_W-1:0] cfg_wdata,
	rcs_req_if.sink                    req,
	rcs_cpl_if.source                  cpl
);
	import rcs_pkg::*;

	rcs_cmd_t  cmd;
	rcs_stat_t stat;
	req_t      req_payload;
	cpl_t      cpl_payload;

	// Gather the request fields into one word for the datapath.
	always_comb begin
		req_payload.request_address    = req.request_address;
		req_payload.request_length     = req.request_length;
		req_payload.request_tag        = req.request_tag;
		req_payload.traffic_class      = req.traffic_class;
		req_payload.requester_bus      = req.requester_bus;
		req_payload.requester_device   = req.requester_device;
		req_payload.requester_function = req.requester_function;
	end

	// The controller sequences the pieces; it sees only the handshake and status.
	rcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The datapath holds the running address and remaining count of the request
	// and the registered completion header.
	rcs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_payload),
		.cmd       (cmd),
		.stat      (stat),
		.cpl       (cpl_payload),
		.cpl_valid (cpl.valid),
		.cpl_ready (cpl.ready)
	);

	assign cpl.piece_address     = cpl_payload.piece_address;
	assign cpl.piece_length      = cpl_payload.piece_length;
	assign cpl.remaining_count   = cpl_payload.remaining_count;
	assign cpl.cpl_tag           = cpl_payload.cpl_tag;
	assign cpl.cpl_traffic_class = cpl_payload.cpl_traffic_class;
	assign cpl.cpl_bus           = cpl_payload.cpl_bus;
	assign cpl.cpl_device        = cpl_payload.cpl_device;
	assign cpl.cpl_function      = cpl_payload.cpl_function;
	assign cpl.last_piece        = cpl_payload.last_piece;

	// A request with work to do keeps the block busy in the next cycle.
	`RCS_ASSERT(a_busy_after_accept, clk, arst_n, (req.valid && req.ready && req.request_length != '0) |=> !req.ready, "request accepted but block not busy")
	// Every piece carries at least one doubleword and never more than is outstanding.
	`RCS_ASSERT_IMP(a_piece_bounds, clk, arst_n, cpl.valid, (cpl.piece_length != '0) && (cpl.piece_length <= cpl.remaining_count), "piece length out of bounds")
	// The last piece is exactly the one that takes all that remains.
	`RCS_ASSERT_IMP(a_last_consistent, clk, arst_n, cpl.valid, cpl.last_piece == (cpl.piece_length == cpl.remaining_count), "last flag disagrees with counts")
endmodule

/* src/rcs_ctrl.sv */
module rcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output rcs_pkg::rcs_cmd_t  cmd,
	input  rcs_pkg::rcs_stat_t stat
);
	import rcs_pkg::*;

	rcs_state_t state_q;
	rcs_state_t state_d;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step = (state_q == ST_RUN) && stat.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				// A zero-length request is taken and dropped.
				if (in_valid && !stat.len_zero) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.step && stat.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* src/rcs_datapath.sv */
module rcs_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rcs_pkg::LOG2_W-1:0] cfg_wdata,
	input  rcs_pkg::req_t              req,
	input  rcs_pkg::rcs_cmd_t          cmd,
	output rcs_pkg::rcs_stat_t         stat,
	output rcs_pkg::cpl_t              cpl,
	output logic                       cpl_valid,
	input  logic                       cpl_ready
);
	import rcs_pkg::*;

	logic [LOG2_W-1:0] log2_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  rem_q;
	logic [7:0]        tag_q;
	logic [2:0]        tc_q;
	logic [7:0]        bus_q;
	logic [4:0]        dev_q;
	logic [2:0]        fn_q;
	cpl_t              cpl_q;
	logic              cpl_valid_q;

	logic [LEN_W-1:0]  blk;
	logic [LEN_W-1:0]  offset;
	logic [LEN_W-1:0]  chunk;
	logic [LEN_W-1:0]  piece_len;
	logic              last;
	logic [LEN_W-1:0]  len_sat;

	// The stored boundary is already clamped to the legal range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= LOG2_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < LOG2_MIN) begin
				log2_q <= LOG2_MIN;
			end else if (cfg_wdata > LOG2_MAX) begin
				log2_q <= LOG2_MAX;
			end else begin
				log2_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		blk       = LEN_W'(1) << log2_q;
		offset    = addr_q[LEN_W-1:0] & (blk - LEN_W'(1));
		chunk     = blk - offset;
		last      = (chunk >= rem_q);
		piece_len = last ? rem_q : chunk;
		len_sat   = (req.request_length > LEN_W'(MAX_READ_LENGTH)) ?
		            LEN_W'(MAX_READ_LENGTH) : req.request_length;
	end

	always_comb begin
		stat.len_zero = (req.request_length == '0);
		stat.last     = last;
		stat.out_free = !cpl_valid_q || cpl_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= req.request_address;
			rem_q  <= len_sat;
			tag_q  <= req.request_tag;
			tc_q   <= req.traffic_class;
			bus_q  <= req.requester_bus;
			dev_q  <= req.requester_device;
			fn_q   <= req.requester_function;
		end else if (cmd.step) begin
			addr_q <= addr_q + ADDR_W'(piece_len);
			rem_q  <= rem_q - piece_len;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			cpl_q.piece_address     <= addr_q;
			cpl_q.piece_length      <= piece_len;
			cpl_q.remaining_count   <= rem_q;
			cpl_q.cpl_tag           <= tag_q;
			cpl_q.cpl_traffic_class <= tc_q;
			cpl_q.cpl_bus           <= bus_q;
			cpl_q.cpl_device        <= dev_q;
			cpl_q.cpl_function      <= fn_q;
			cpl_q.last_piece        <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_valid_q <= 1'b0;
		end else if (cmd.step) begin
			cpl_valid_q <= 1'b1;
		end else if (cpl_ready) begin
			cpl_valid_q <= 1'b0;
		end
	end

	assign cpl       = cpl_q;
	assign cpl_valid = cpl_valid_q;
endmodule

/* bench/read_completion_splitter_core_tb.sv */
module read_completion_splitter_core_tb;
	import rcs_pkg::*;

	// Cycles to let pass before a boundary write or the end of the run. A zero-length
	// request gives no completion that could tell us when it has finished.
	localparam int unsigned DRAIN_CYCLES = 40;
	// Cycles with no request and no completion accepted before the run is called hung.
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_REQUESTS = 24;

	// The tracker splits every accepted read request into the completion headers
	// it should cause, keeps them in arrival order and compares each completion
	// that the splitter hands out against the oldest one still waiting.
	class completion_tracker;
		cpl_t              expected_pieces[$];
		logic [LOG2_W-1:0] boundary_log2;
		int unsigned       failures;
		int unsigned       requests_seen;
		int unsigned       pieces_checked;

		function new();
			boundary_log2 = LOG2_RESET;
		endfunction

		function void set_boundary(logic [LOG2_W-1:0] value);
			boundary_log2 = value;
		endfunction

		function int unsigned pending();
			return expected_pieces.size();
		endfunction

		function void note_request(req_t r);
			logic [ADDR_W-1:0] addr;
			int unsigned       remaining;
			int unsigned       log2_used;
			int unsigned       blk;
			int unsigned       chunk;
			cpl_t              p;
			requests_seen++;
			// A zero-length read is dropped without any completion.
			if (r.request_length == '0) return;
			// Lengths past the largest legal read are cut down to it.
			remaining = 32'(r.request_length);
			if (remaining > MAX_READ_LENGTH) remaining = MAX_READ_LENGTH;
			// Boundary settings outside the legal span are pulled to its nearest end.
			log2_used = 32'(boundary_log2);
			if (log2_used < 32'(LOG2_MIN)) log2_used = 32'(LOG2_MIN);
			if (log2_used > 32'(LOG2_MAX)) log2_used = 32'(LOG2_MAX);
			blk  = 32'd1 << log2_used;
			addr = r.request_address;
			while (remaining > 0) begin
				chunk = blk - (32'(addr) & (blk - 1));
				p.last_piece = 1'b0;
				if (chunk >= remaining) begin
					chunk        = remaining;
					p.last_piece = 1'b1;
				end
				p.piece_address     = addr;
				p.piece_length      = LEN_W'(chunk);
				p.remaining_count   = LEN_W'(remaining);
				p.cpl_tag           = r.request_tag;
				p.cpl_traffic_class = r.traffic_class;
				p.cpl_bus           = r.requester_bus;
				p.cpl_device        = r.requester_device;
				p.cpl_function      = r.requester_function;
				expected_pieces = {expected_pieces, p};
				// The address is only 30 bits wide, so a piece past the top wraps to zero.
				addr      = ADDR_W'(32'(addr) + chunk);
				remaining = remaining - chunk;
			end
		endfunction

		function void match(string field, longint unsigned want, longint unsigned got);
			if (want !== got) begin
				failures++;
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			end
		endfunction

		function void check_piece(cpl_t got);
			cpl_t want;
			if (expected_pieces.size() == 0) begin
				failures++;
				$error("completion header at address 0x%0h with no request outstanding",
					got.piece_address);
				return;
			end
			want = expected_pieces.pop_front();
			pieces_checked++;
			match("piece_address", want.piece_address, got.piece_address);
			match("piece_length", want.piece_length, got.piece_length);
			match("remaining_count", want.remaining_count, got.remaining_count);
			match("cpl_tag", want.cpl_tag, got.cpl_tag);
			match("cpl_traffic_class", want.cpl_traffic_class, got.cpl_traffic_class);
			match("cpl_bus", want.cpl_bus, got.cpl_bus);
			match("cpl_device", want.cpl_device, got.cpl_device);
			match("cpl_function", want.cpl_function, got.cpl_function);
			match("last_piece", want.last_piece, got.last_piece);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [LOG2_W-1:0] cfg_wdata;

	rcs_req_if read_req ();
	rcs_cpl_if cpl_hdr ();

	completion_tracker book = new();

	int unsigned idle_cycles = 0;
	int unsigned settings_used = 0;
	// While one of these is set, that side runs without any gaps for a while.
	bit          sender_calm = 1'b0;
	bit          receiver_calm = 1'b0;

	read_completion_splitter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (read_req),
		.cpl      (cpl_hdr)
	);

	always #10 clk = ~clk;

	// Gap lengths: half of them none, most of the rest short and a few long.
	function automatic int unsigned pick_gap(bit calm);
		int unsigned roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_request(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
		logic [7:0] tag, logic [2:0] tc, logic [7:0] bus, logic [4:0] dev, logic [2:0] fn);
		req_t r;
		r.request_address    = addr;
		r.request_length     = len;
		r.request_tag        = tag;
		r.traffic_class      = tc;
		r.requester_bus      = bus;
		r.requester_device   = dev;
		r.requester_function = fn;
		return r;
	endfunction

	// Random requests lean toward the cases where splitting goes wrong: addresses
	// just short of a boundary or of the top of the address space, lengths that
	// end exactly on a boundary, the longest reads, and the out-of-range lengths.
	function automatic req_t random_request();
		req_t        r;
		int unsigned blk;
		int unsigned roll;
		blk  = 32 << $urandom_range(0, 5);
		roll = $urandom_range(0, 99);
		if (roll < 60)
			r.request_address = ADDR_W'($urandom);
		else if (roll < 80)
			r.request_address = ADDR_W'(($urandom & ~(blk - 1)) - $urandom_range(0, 3));
		else if (roll < 90)
			r.request_address = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 2047));
		else
			r.request_address = ADDR_W'($urandom & ~(blk - 1));
		roll = $urandom_range(0, 99);
		if (roll < 40)
			r.request_length = LEN_W'($urandom_range(1, 64));
		else if (roll < 65)
			r.request_length = LEN_W'($urandom_range(1, MAX_READ_LENGTH));
		else if (roll < 75)
			r.request_length = LEN_W'(blk - (32'(r.request_address) & (blk - 1)));
		else if (roll < 85)
			r.request_length = LEN_W'(MAX_READ_LENGTH);
		else if (roll < 92)
			r.request_length = LEN_W'($urandom_range(MAX_READ_LENGTH + 1, (1 << LEN_W) - 1));
		else if (roll < 97)
			r.request_length = '0;
		else
			r.request_length = LEN_W'($urandom_range(1, 4));
		r.request_tag        = 8'($urandom);
		r.traffic_class      = 3'($urandom);
		r.requester_bus      = 8'($urandom);
		r.requester_device   = 5'($urandom);
		r.requester_function = 3'($urandom);
		return r;
	endfunction

	// Presents one request after a random gap and returns at the edge where the
	// splitter takes it. Valid stays high when the next request follows at once.
	task automatic send_request(input req_t r);
		int unsigned gap;
		if ($urandom_range(0, 15) == 0) sender_calm = ~sender_calm;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			read_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		read_req.valid              <= 1'b1;
		read_req.request_address    <= r.request_address;
		read_req.request_length     <= r.request_length;
		read_req.request_tag        <= r.request_tag;
		read_req.traffic_class      <= r.traffic_class;
		read_req.requester_bus      <= r.requester_bus;
		read_req.requester_device   <= r.requester_device;
		read_req.requester_function <= r.requester_function;
		@(posedge clk);
		while (!read_req.ready) @(posedge clk);
	endtask

	// Lets the splitter run dry, including any zero-length request that may still
	// be in flight, so that a new boundary never lands in the middle of a split.
	task automatic drain();
		read_req.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_boundary(input logic [LOG2_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_boundary(value);
		settings_used++;
	endtask

	// The boundary at reset is 32 doublewords, which gives the most pieces, so
	// the directed requests run there before any write.
	task automatic run_directed();
		send_request(make_request(30'h0, 11'd1, 8'h00, 3'd0, 8'h00, 5'd0, 3'd0));
		send_request(make_request(30'h3FFF_FFFF, 11'd1, 8'hFF, 3'd7, 8'hFF, 5'h1F, 3'd7));
		// A zero-length read must vanish without a trace.
		send_request(make_request(30'h0, 11'd0, 8'h5A, 3'd3, 8'h11, 5'd9, 3'd2));
		// Reads that end on a boundary, or one past it, must not grow an empty last piece.
		send_request(make_request(30'h0, 11'd32, 8'h01, 3'd1, 8'h02, 5'd3, 3'd4));
		send_request(make_request(30'h10, 11'd16, 8'h02, 3'd2, 8'h04, 5'd5, 3'd6));
		send_request(make_request(30'h40, 11'd33, 8'h03, 3'd5, 8'h08, 5'd7, 3'd1));
		// The longest read, first unaligned for 33 pieces, then aligned for 32.
		send_request(make_request(30'h1F, 11'd1024, 8'h80, 3'd4, 8'h80, 5'h10, 3'd4));
		send_request(make_request(30'h0, 11'd1024, 8'h7F, 3'd3, 8'h7F, 5'h0F, 3'd3));
		// Pieces that run past the top of the address space wrap to zero.
		send_request(make_request(30'h3FFF_FFF0, 11'd64, 8'hC3, 3'd6, 8'h3C, 5'h15, 3'd5));
		send_request(make_request(30'h3FFF_FFFF, 11'd1024, 8'h3C, 3'd1, 8'hC3, 5'h0A, 3'd2));
		// Lengths above the largest read are saturated, then a legal and a zero length follow.
		send_request(make_request(30'h5, 11'd1025, 8'hAA, 3'd2, 8'h55, 5'h0A, 3'd5));
		send_request(make_request(30'h7, 11'h7FF, 8'h55, 3'd5, 8'hAA, 5'h15, 3'd2));
		send_request(make_request(30'h2AAA_AAAA, 11'h555, 8'hF0, 3'd7, 8'h0F, 5'h1F, 3'd0));
		send_request(make_request(30'h1555_5555, 11'h2AA, 8'h0F, 3'd0, 8'hF0, 5'h00, 3'd7));
		send_request(make_request(30'h3FFF_FFE0, 11'd0, 8'hFF, 3'd7, 8'hFF, 5'h1F, 3'd7));
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count) send_request(random_request());
	endtask

	// Watches both channels. Requests feed the tracker and completions are checked
	// against it; the values seen here are those from just before the edge, so the
	// order of processes at the edge does not matter.
	always @(posedge clk) begin : observe
		req_t r;
		cpl_t c;
		bit   moved;
		moved = 1'b0;
		if (arst_n) begin
			if (read_req.valid && read_req.ready) begin
				r.request_address    = read_req.request_address;
				r.request_length     = read_req.request_length;
				r.request_tag        = read_req.request_tag;
				r.traffic_class      = read_req.traffic_class;
				r.requester_bus      = read_req.requester_bus;
				r.requester_device   = read_req.requester_device;
				r.requester_function = read_req.requester_function;
				book.note_request(r);
				moved = 1'b1;
			end
			if (cpl_hdr.valid && cpl_hdr.ready) begin
				c.piece_address     = cpl_hdr.piece_address;
				c.piece_length      = cpl_hdr.piece_length;
				c.remaining_count   = cpl_hdr.remaining_count;
				c.cpl_tag           = cpl_hdr.cpl_tag;
				c.cpl_traffic_class = cpl_hdr.cpl_traffic_class;
				c.cpl_bus           = cpl_hdr.cpl_bus;
				c.cpl_device        = cpl_hdr.cpl_device;
				c.cpl_function      = cpl_hdr.cpl_function;
				c.last_piece        = cpl_hdr.last_piece;
				book.check_piece(c);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("No progress for %0d cycles, %0d completions still expected.",
					idle_cycles, book.pending());
				$display("read_completion_splitter_core verification failed");
				$finish;
			end
		end
	end

	// The completion side takes headers in bursts of random length and may stall in
	// between, with the odd long burst that never stalls.
	initial begin : completion_backpressure
		int unsigned burst;
		int unsigned stall;
		cpl_hdr.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) receiver_calm = ~receiver_calm;
			burst = receiver_calm ? $urandom_range(100, 300) : $urandom_range(1, 12);
			cpl_hdr.ready <= 1'b1;
			repeat (burst) @(posedge clk);
			stall = pick_gap(receiver_calm);
			if (stall > 0) begin
				cpl_hdr.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		// Boundary settings after the directed part: both ends of the legal span,
		// values below and above it that must be clamped, and the ones between.
		logic [LOG2_W-1:0] settings[10];
		settings = '{4'd0, 4'd10, 4'd4, 4'd15, 4'd7, 4'd5, 4'd11, 4'd6, 4'd8, 4'd9};
		cfg_we                      <= 1'b0;
		cfg_wdata                   <= '0;
		read_req.valid              <= 1'b0;
		read_req.request_address    <= '0;
		read_req.request_length     <= '0;
		read_req.request_tag        <= '0;
		read_req.traffic_class      <= '0;
		read_req.requester_bus      <= '0;
		read_req.requester_device   <= '0;
		read_req.requester_function <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		foreach (settings[i]) begin
			write_boundary(settings[i]);
			run_random(PHASE_REQUESTS);
		end
		// One last phase at a setting of the simulator's choosing.
		write_boundary(LOG2_W'($urandom_range(0, (1 << LOG2_W) - 1)));
		run_random(PHASE_REQUESTS / 2);
		drain();

		$display("Split %0d read requests into %0d checked completion headers",
			book.requests_seen, book.pieces_checked);
		$display("across %0d boundary settings, clamped ones included.", settings_used + 1);
		if (book.failures == 0 && book.pending() == 0) begin
			$display("read_completion_splitter_core verification clean");
		end else begin
			$display("read_completion_splitter_core verification failed");
		end
		$finish;
	end

endmodule
